[hw/rtl/dcc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the command packet builder.
// Depends on nothing; the slot table, the core and the bench refer to it by scoped names.

package dcc_pkg;

   // One entry of the throttle speed table.
   typedef struct packed {
      logic [13:0] address;
      logic [6:0]  speed;
      logic        forward;
   } slot_entry_type;

   localparam slot_entry_type SLOT_RESET = '{address: 14'd0, speed: 7'd0, forward: 1'b1};

   // Write request from the control logic into the speed table.
   typedef struct packed {
      logic           enable;
      slot_entry_type entry;
   } slot_wr_type;

   // The slot count register is five bits wide, so no more slots are ever addressed.
   localparam int unsigned SLOT_REG_MAX = 31;

   // Command codes.
   localparam logic [3:0] ACT_THROTTLE   = 4'd0;
   localparam logic [3:0] ACT_FUNC_GROUP = 4'd1;
   localparam logic [3:0] ACT_FUNC_TWO   = 4'd2;
   localparam logic [3:0] ACT_ACCESSORY  = 4'd3;
   localparam logic [3:0] ACT_CV_WRITE   = 4'd4;
   localparam logic [3:0] ACT_CV_BIT     = 4'd5;
   localparam logic [3:0] ACT_CV_READ    = 4'd6;
   localparam logic [3:0] ACT_CV_LONG    = 4'd7;
   localparam logic [3:0] ACT_REFRESH    = 4'd8;

   // Packet kinds reported with every result.
   localparam logic [2:0] KIND_THROTTLE  = 3'd0;
   localparam logic [2:0] KIND_FUNCTION  = 3'd1;
   localparam logic [2:0] KIND_ACCESSORY = 3'd2;
   localparam logic [2:0] KIND_CV_WRITE  = 3'd3;
   localparam logic [2:0] KIND_CV_BIT    = 3'd4;
   localparam logic [2:0] KIND_CV_READ   = 3'd5;
   localparam logic [2:0] KIND_CV_LONG   = 3'd6;

   // Extra transmissions requested per packet type.
   localparam logic [2:0] REP_THROTTLE = 3'd0;
   localparam logic [2:0] REP_DEFAULT  = 3'd3;
   localparam logic [2:0] REP_CV_BIT   = 3'd4;

   // Packet byte constants.
   localparam logic [7:0] LONG_ADDR_TAG  = 8'hC0;
   localparam logic [7:0] SPEED_128_OP   = 8'h3F;
   localparam logic [7:0] FUNC_ONE_SET   = 8'h80;
   localparam logic [7:0] FUNC_ONE_MASK  = 8'hBF;
   localparam logic [7:0] FUNC_TWO_SET   = 8'hDE;
   localparam logic [7:0] FUNC_TWO_MASK  = 8'hDF;
   localparam logic [7:0] ACC_FIRST_BASE = 8'h80;
   localparam logic [7:0] ACC_SECOND_XOR = 8'hF8;
   localparam logic [7:0] OP_CV_WRITE    = 8'hEC;
   localparam logic [7:0] OP_CV_BIT      = 8'hE8;
   localparam logic [7:0] CV_BIT_BASE    = 8'hF0;
   localparam logic [7:0] OP_CV_READ     = 8'hE4;
   localparam logic [7:0] OP_CV_LONG     = 8'hE0;

endpackage

`default_nettype wire

[hw/rtl/dcc_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// Command channel of the packet builder: valid/ready handshake and command fields.
// Depends on nothing.

interface dcc_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  action;
   logic [7:0]  slot;
   logic [13:0] address;
   logic [6:0]  speed;
   logic        direction;
   logic [7:0]  data_one;
   logic [7:0]  data_two;
   logic [15:0] cv_number;
   logic        queue_empty;

   modport source (
      output valid, action, slot, address, speed, direction, data_one, data_two,
             cv_number, queue_empty,
      input  ready
   );

   modport sink (
      input  valid, action, slot, address, speed, direction, data_one, data_two,
             cv_number, queue_empty,
      output ready
   );
endinterface

`default_nettype wire

[hw/rtl/dcc_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// Result channel of the packet builder: valid/ready handshake and one packet byte per item.
// Depends on nothing.

interface dcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic        last_byte;
   logic        packet_valid;
   logic        status;
   logic [2:0]  repeat_count;
   logic [2:0]  packet_kind;
   logic [15:0] railcom_address;
   logic [15:0] transaction_id;

   modport source (
      output valid, payload_byte, last_byte, packet_valid, status, repeat_count,
             packet_kind, railcom_address, transaction_id,
      input  ready
   );

   modport sink (
      input  valid, payload_byte, last_byte, packet_valid, status, repeat_count,
             packet_kind, railcom_address, transaction_id,
      output ready
   );
endinterface

`default_nettype wire

[hw/rtl/dcc_slot_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// Throttle speed table: one synchronous memory with one write and one registered read port.
// Depends on dcc_pkg for the entry and write request types.

module dcc_slot_table #(
   parameter int unsigned  MAX_SLOTS = 31,
   localparam int unsigned DEPTH     = MAX_SLOTS + 1,
   localparam int unsigned SLOT_W    = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dcc_pkg::slot_wr_type  wr_req,
   input  wire logic [SLOT_W-1:0]     wr_addr,
   input  wire logic [SLOT_W-1:0]     rd_addr,
   output dcc_pkg::slot_entry_type    rd_entry
);

   dcc_pkg::slot_entry_type slot_mem_ff [DEPTH];
   dcc_pkg::slot_entry_type rd_data_ff;
   logic [DEPTH-1:0]        written_ff;
   logic [DEPTH-1:0]        written_in;
   logic                    rd_written_ff;

   // Entries never written since reset read back as the reset entry.
   always_comb begin
      written_in = written_ff;
      if (wr_req.enable) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_req.enable) begin
         slot_mem_ff[wr_addr] <= wr_req.entry;
      end
      rd_data_ff <= slot_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         written_ff    <= written_in;
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   assign rd_entry = rd_written_ff ? rd_data_ff : dcc_pkg::SLOT_RESET;

endmodule

`default_nettype wire

[hw/rtl/dcc_command_packet_builder_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Command packet builder for a model-railway track signal.
// Uses dcc_pkg, the dcc_req_if and dcc_rsp_if channels, and dcc_slot_table.
//
// Usage: one command item enters on req_ch; the block answers on rsp_ch with the payload
// bytes of the track packet, one byte per item, then the XOR checksum byte with last_byte
// set. A throttle command to a slot outside 1..active slots gives a single item with status
// set and nothing else. A refresh command with a busy queue, with no active slot, or an
// unknown command gives no item at all. csr_write_data sets the active slot count; write
// it only while the block is idle.
// Timing: req_ch.ready is high only while the block is idle. After acceptance ST_BUILD
// builds the packet, 3 to 6 bytes with checksum, into a byte buffer; then ST_EMIT moves
// the bytes one at a time into the output register and returns to idle once the last
// byte has entered it. A refresh first reads the speed table one slot at a time, in
// ST_SCAN_RD (address) and ST_SCAN_CHK (registered data), until a slot holds a nonzero
// address or every valid slot has been examined.
// Stalls: the output register holds its item while rsp_ch.ready is low; the byte buffer
// then waits, and a new command is taken as soon as the last byte has entered the output
// register, even if that byte is still waiting there.
// Reset: synchronous; clears the control state, the transaction counter, the refresh
// pointer and the table's written flags, and sets the active slot count to 31.

module dcc_command_packet_builder_core #(
   parameter int unsigned MAX_SLOTS = 31
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [4:0] csr_write_data,
   dcc_req_if.sink         req_ch,
   dcc_rsp_if.source       rsp_ch
);

   localparam int unsigned DEPTH    = MAX_SLOTS + 1;
   localparam int unsigned SLOT_W   = $clog2(DEPTH);
   // Largest usable slot count: limited by both the table and the count register.
   localparam int unsigned SLOT_CAP =
      (MAX_SLOTS > dcc_pkg::SLOT_REG_MAX) ? dcc_pkg::SLOT_REG_MAX : MAX_SLOTS;
   localparam int unsigned BUF_BYTES = 6;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_BUILD    = 5'b00010,
      ST_SCAN_RD  = 5'b00100,
      ST_SCAN_CHK = 5'b01000,
      ST_EMIT     = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Configuration and persistent state.
   logic [4:0]  active_ff, active_in;
   logic [4:0]  pointer_ff, pointer_in;
   logic [15:0] counter_ff, counter_in;

   // Latched command.
   logic [3:0]  cmd_action_ff, cmd_action_in;
   logic [7:0]  cmd_slot_ff, cmd_slot_in;
   logic [13:0] cmd_addr_ff, cmd_addr_in;
   logic [6:0]  cmd_speed_ff, cmd_speed_in;
   logic        cmd_dir_ff, cmd_dir_in;
   logic [7:0]  cmd_d1_ff, cmd_d1_in;
   logic [7:0]  cmd_d2_ff, cmd_d2_in;
   logic [15:0] cmd_cv_ff, cmd_cv_in;
   logic        refresh_ff, refresh_in;

   // Refresh scan.
   logic [4:0]  scan_slot_ff, scan_slot_in;
   logic [4:0]  scan_left_ff, scan_left_in;

   // Packet buffer and its description.
   logic [7:0]  buf_ff [BUF_BYTES];
   logic [7:0]  buf_in [BUF_BYTES];
   logic [2:0]  total_ff, total_in;
   logic [2:0]  idx_ff, idx_in;
   logic        err_ff, err_in;
   logic [2:0]  rep_ff, rep_in;
   logic [2:0]  kind_ff, kind_in;
   logic [15:0] rc_ff, rc_in;
   logic [15:0] tid_ff, tid_in;

   // Output register.
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic        out_pkt_ff, out_pkt_in;
   logic        out_status_ff, out_status_in;
   logic [2:0]  out_rep_ff, out_rep_in;
   logic [2:0]  out_kind_ff, out_kind_in;
   logic [15:0] out_rc_ff, out_rc_in;
   logic [15:0] out_tid_ff, out_tid_in;

   // Speed table connections.
   dcc_pkg::slot_wr_type    tbl_wr;
   dcc_pkg::slot_entry_type tbl_rd;
   logic [SLOT_W-1:0]       tbl_wr_addr;
   logic [SLOT_W-1:0]       tbl_rd_addr;

   dcc_slot_table #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_slot_table (
      .clock    (clock),
      .reset    (reset),
      .wr_req   (tbl_wr),
      .wr_addr  (tbl_wr_addr),
      .rd_addr  (tbl_rd_addr),
      .rd_entry (tbl_rd)
   );

   // Valid slot count: the register value, capped by the table size.
   logic [4:0] valid_count;
   assign valid_count = (active_ff > 5'(SLOT_CAP)) ? 5'(SLOT_CAP) : active_ff;

   logic accept;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // Refresh starts at the stored pointer, or at slot one when it is out of range.
   logic [4:0] scan_start;
   assign scan_start = (pointer_ff == 5'd0 || pointer_ff > valid_count) ? 5'd1 : pointer_ff;

   logic [4:0] scan_next;
   assign scan_next = (scan_slot_ff == valid_count) ? 5'd1 : scan_slot_ff + 5'd1;

   // ---------------------------------------------------------------------------------
   // Packet assembly from the latched command: an address prefix, where the form has one, then a tail.
   // ---------------------------------------------------------------------------------
   logic        long_addr;
   logic [7:0]  addr_hi, addr_lo;
   logic [9:0]  cv_index;
   logic [39:0] tail_vec;
   logic [2:0]  tail_len;
   logic [1:0]  pre_len;
   logic [39:0] pkt_vec;
   logic [2:0]  pkt_len;
   logic [7:0]  checksum;
   logic [2:0]  pkt_rep;
   logic [2:0]  pkt_kind;
   logic [15:0] pkt_rc;
   logic [6:0]  speed_step;
   logic        slot_bad;

   assign long_addr  = |cmd_addr_ff[13:7];
   assign addr_hi    = {2'b00, cmd_addr_ff[13:8]} | dcc_pkg::LONG_ADDR_TAG;
   assign addr_lo    = cmd_addr_ff[7:0];
   assign cv_index   = cmd_cv_ff[9:0] - 10'd1;
   // Speed step one is skipped: it is the emergency stop code.
   assign speed_step = cmd_speed_ff + {6'd0, |cmd_speed_ff};
   assign slot_bad   = (cmd_slot_ff == 8'd0) || (cmd_slot_ff > {3'd0, valid_count});

   always_comb begin
      tail_vec = '0;
      tail_len = 3'd2;
      pre_len  = long_addr ? 2'd2 : 2'd1;
      pkt_rc   = long_addr ? {addr_hi, addr_lo} : {8'd0, addr_lo};
      pkt_rep  = dcc_pkg::REP_DEFAULT;
      pkt_kind = dcc_pkg::KIND_THROTTLE;
      case (cmd_action_ff)
         dcc_pkg::ACT_FUNC_GROUP: begin
            tail_vec[39:32] = (cmd_d1_ff | dcc_pkg::FUNC_ONE_SET) & dcc_pkg::FUNC_ONE_MASK;
            tail_len        = 3'd1;
            pkt_kind        = dcc_pkg::KIND_FUNCTION;
         end
         dcc_pkg::ACT_FUNC_TWO: begin
            tail_vec[39:32] = (cmd_d1_ff | dcc_pkg::FUNC_TWO_SET) & dcc_pkg::FUNC_TWO_MASK;
            tail_vec[31:24] = cmd_d2_ff;
            pkt_kind        = dcc_pkg::KIND_FUNCTION;
         end
         dcc_pkg::ACT_ACCESSORY: begin
            // The accessory form carries its own address bits in both bytes.
            pre_len         = 2'd0;
            tail_vec[39:32] = {2'b00, cmd_addr_ff[5:0]} + dcc_pkg::ACC_FIRST_BASE;
            tail_vec[31:24] = {1'b0, cmd_addr_ff[8:6], 1'b0, cmd_d1_ff[1:0], cmd_dir_ff}
                              ^ dcc_pkg::ACC_SECOND_XOR;
            pkt_rc          = tail_vec[39:24];
            pkt_kind        = dcc_pkg::KIND_ACCESSORY;
         end
         dcc_pkg::ACT_CV_WRITE: begin
            tail_vec[39:32] = {dcc_pkg::OP_CV_WRITE[7:2], cv_index[9:8]};
            tail_vec[31:24] = cv_index[7:0];
            tail_vec[23:16] = cmd_d1_ff;
            tail_len        = 3'd3;
            pkt_kind        = dcc_pkg::KIND_CV_WRITE;
         end
         dcc_pkg::ACT_CV_BIT: begin
            tail_vec[39:32] = {dcc_pkg::OP_CV_BIT[7:2], cv_index[9:8]};
            tail_vec[31:24] = cv_index[7:0];
            tail_vec[23:16] = dcc_pkg::CV_BIT_BASE | {4'd0, cmd_d1_ff[0], cmd_d2_ff[2:0]};
            tail_len        = 3'd3;
            pkt_rep         = dcc_pkg::REP_CV_BIT;
            pkt_kind        = dcc_pkg::KIND_CV_BIT;
         end
         dcc_pkg::ACT_CV_READ: begin
            tail_vec[39:32] = {dcc_pkg::OP_CV_READ[7:2], cv_index[9:8]};
            tail_vec[31:24] = cv_index[7:0];
            tail_len        = 3'd3;
            pkt_kind        = dcc_pkg::KIND_CV_READ;
         end
         dcc_pkg::ACT_CV_LONG: begin
            tail_vec[39:32] = {dcc_pkg::OP_CV_LONG[7:2], cv_index[9:8]};
            tail_vec[31:24] = cv_index[7:0];
            pkt_kind        = dcc_pkg::KIND_CV_LONG;
         end
         default: begin
            // Throttle, both direct and from a refresh.
            tail_vec[39:32] = dcc_pkg::SPEED_128_OP;
            tail_vec[31:24] = {cmd_dir_ff, speed_step};
            pkt_rep         = dcc_pkg::REP_THROTTLE;
         end
      endcase

      case (pre_len)
         2'd2:    pkt_vec = {addr_hi, addr_lo, tail_vec[39:16]};
         2'd1:    pkt_vec = {addr_lo, tail_vec[39:8]};
         default: pkt_vec = tail_vec;
      endcase
      pkt_len = {1'b0, pre_len} + tail_len;

      checksum = 8'd0;
      for (int k = 0; k < BUF_BYTES - 1; k++) begin
         if (3'(k) < pkt_len) begin
            checksum = checksum ^ pkt_vec[39 - 8 * k -: 8];
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------------------
   logic out_load;
   assign out_load = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      pointer_in    = pointer_ff;
      counter_in    = counter_ff;
      cmd_action_in = cmd_action_ff;
      cmd_slot_in   = cmd_slot_ff;
      cmd_addr_in   = cmd_addr_ff;
      cmd_speed_in  = cmd_speed_ff;
      cmd_dir_in    = cmd_dir_ff;
      cmd_d1_in     = cmd_d1_ff;
      cmd_d2_in     = cmd_d2_ff;
      cmd_cv_in     = cmd_cv_ff;
      refresh_in    = refresh_ff;
      scan_slot_in  = scan_slot_ff;
      scan_left_in  = scan_left_ff;
      buf_in        = buf_ff;
      total_in      = total_ff;
      idx_in        = idx_ff;
      err_in        = err_ff;
      rep_in        = rep_ff;
      kind_in       = kind_ff;
      rc_in         = rc_ff;
      tid_in        = tid_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_pkt_in    = out_pkt_ff;
      out_status_in = out_status_ff;
      out_rep_in    = out_rep_ff;
      out_kind_in   = out_kind_ff;
      out_rc_in     = out_rc_ff;
      out_tid_in    = out_tid_ff;
      tbl_wr.enable = 1'b0;
      tbl_wr.entry  = '{address: cmd_addr_ff, speed: cmd_speed_ff, forward: cmd_dir_ff};
      tbl_wr_addr   = SLOT_W'(cmd_slot_ff);
      tbl_rd_addr   = SLOT_W'(scan_slot_ff);

      if (csr_write_enable) begin
         active_in = csr_write_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_action_in = req_ch.action;
               cmd_slot_in   = req_ch.slot;
               cmd_addr_in   = req_ch.address;
               cmd_speed_in  = (req_ch.speed > 7'd126) ? 7'd126 : req_ch.speed;
               cmd_dir_in    = req_ch.direction;
               cmd_d1_in     = req_ch.data_one;
               cmd_d2_in     = req_ch.data_two;
               cmd_cv_in     = req_ch.cv_number;
               refresh_in    = 1'b0;
               scan_slot_in  = scan_start;
               scan_left_in  = valid_count;
               if (req_ch.action == dcc_pkg::ACT_REFRESH) begin
                  // Refresh runs only with an empty queue and at least one slot.
                  if (req_ch.queue_empty && valid_count != 5'd0) begin
                     state_in = ST_SCAN_RD;
                  end
               end else if (req_ch.action < dcc_pkg::ACT_REFRESH) begin
                  state_in = ST_BUILD;
               end
            end
         end

         ST_SCAN_RD: begin
            // The table address is scan_slot_ff; its entry is ready next cycle.
            state_in = ST_SCAN_CHK;
         end

         ST_SCAN_CHK: begin
            if (tbl_rd.address != 14'd0) begin
               cmd_action_in = dcc_pkg::ACT_THROTTLE;
               cmd_addr_in   = tbl_rd.address;
               cmd_speed_in  = tbl_rd.speed;
               cmd_dir_in    = tbl_rd.forward;
               refresh_in    = 1'b1;
               pointer_in    = scan_next;
               state_in      = ST_BUILD;
            end else if (scan_left_ff == 5'd1) begin
               // Every slot examined and none active.
               state_in = ST_IDLE;
            end else begin
               scan_slot_in = scan_next;
               scan_left_in = scan_left_ff - 5'd1;
               state_in     = ST_SCAN_RD;
            end
         end

         ST_BUILD: begin
            idx_in   = 3'd0;
            state_in = ST_EMIT;
            if (cmd_action_ff == dcc_pkg::ACT_THROTTLE && !refresh_ff && slot_bad) begin
               // Out-of-range slot: one zeroed item that only carries the error.
               err_in    = 1'b1;
               total_in  = 3'd1;
               buf_in[0] = 8'd0;
               rep_in    = 3'd0;
               kind_in   = 3'd0;
               rc_in     = 16'd0;
               tid_in    = 16'd0;
            end else begin
               err_in     = 1'b0;
               total_in   = pkt_len + 3'd1;
               rep_in     = pkt_rep;
               kind_in    = pkt_kind;
               rc_in      = pkt_rc;
               counter_in = counter_ff + 16'd1;
               tid_in     = counter_ff + 16'd1;
               for (int k = 0; k < BUF_BYTES - 1; k++) begin
                  buf_in[k] = (3'(k) < pkt_len) ? pkt_vec[39 - 8 * k -: 8] : checksum;
               end
               buf_in[BUF_BYTES-1] = checksum;
               tbl_wr.enable = (cmd_action_ff == dcc_pkg::ACT_THROTTLE) && !refresh_ff;
            end
         end

         ST_EMIT: begin
            if (out_load) begin
               out_valid_in  = 1'b1;
               out_byte_in   = buf_ff[idx_ff];
               out_last_in   = (idx_ff == total_ff - 3'd1);
               out_pkt_in    = !err_ff;
               out_status_in = err_ff;
               out_rep_in    = rep_ff;
               out_kind_in   = kind_ff;
               out_rc_in     = rc_ff;
               out_tid_in    = tid_ff;
               idx_in        = idx_ff + 3'd1;
               if (idx_ff == total_ff - 3'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 5'd31;
         pointer_ff   <= 5'd0;
         counter_ff   <= 16'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         pointer_ff   <= pointer_in;
         counter_ff   <= counter_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_action_ff <= cmd_action_in;
      cmd_slot_ff   <= cmd_slot_in;
      cmd_addr_ff   <= cmd_addr_in;
      cmd_speed_ff  <= cmd_speed_in;
      cmd_dir_ff    <= cmd_dir_in;
      cmd_d1_ff     <= cmd_d1_in;
      cmd_d2_ff     <= cmd_d2_in;
      cmd_cv_ff     <= cmd_cv_in;
      refresh_ff    <= refresh_in;
      scan_slot_ff  <= scan_slot_in;
      scan_left_ff  <= scan_left_in;
      buf_ff        <= buf_in;
      total_ff      <= total_in;
      idx_ff        <= idx_in;
      err_ff        <= err_in;
      rep_ff        <= rep_in;
      kind_ff       <= kind_in;
      rc_ff         <= rc_in;
      tid_ff        <= tid_in;
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
      out_pkt_ff    <= out_pkt_in;
      out_status_ff <= out_status_in;
      out_rep_ff    <= out_rep_in;
      out_kind_ff   <= out_kind_in;
      out_rc_ff     <= out_rc_in;
      out_tid_ff    <= out_tid_in;
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.payload_byte    = out_byte_ff;
   assign rsp_ch.last_byte       = out_last_ff;
   assign rsp_ch.packet_valid    = out_pkt_ff;
   assign rsp_ch.status          = out_status_ff;
   assign rsp_ch.repeat_count    = out_rep_ff;
   assign rsp_ch.packet_kind     = out_kind_ff;
   assign rsp_ch.railcom_address = out_rc_ff;
   assign rsp_ch.transaction_id  = out_tid_ff;

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for dcc_command_packet_builder_core: a directed command table, then
// random command streams under changing slot counts and handshake pressure.
// Depends on dcc_pkg, dcc_req_if, dcc_rsp_if and the core itself.

module testbench;

   // One command as it travels on the request channel.
   typedef struct packed {
      logic [3:0]  action;
      logic [7:0]  slot;
      logic [13:0] address;
      logic [6:0]  speed;
      logic        direction;
      logic [7:0]  data_one;
      logic [7:0]  data_two;
      logic [15:0] cv_number;
      logic        queue_empty;
   } command_type;

   // One item of the result channel: a single packet byte with its side information.
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        last_byte;
      logic        packet_valid;
      logic        status;
      logic [2:0]  repeat_count;
      logic [2:0]  packet_kind;
      logic [15:0] railcom_address;
      logic [15:0] transaction_id;
   } packet_byte_type;

   // How a row of the directed table gets its expectation: from the predictor, or typed in.
   typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_SLOT_ERROR} expect_kind_type;

   typedef struct {
      expect_kind_type kind;
      command_type     command;
   } directed_row_type;

   // A throttle to a slot outside the valid range answers with this single item.
   localparam packet_byte_type SLOT_ERROR = '{payload_byte: 8'h00, last_byte: 1'b1,
                                              packet_valid: 1'b0, status: 1'b1,
                                              repeat_count: 3'd0, packet_kind: 3'd0,
                                              railcom_address: 16'h0000,
                                              transaction_id: 16'h0000};

   localparam int unsigned SETTLE_CYCLES = 100;   // covers a full refresh scan plus build
   localparam int unsigned DRAIN_LIMIT   = 20000;
   localparam int unsigned PHASE_ITEMS   = 40;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic [4:0] csr_write_data;

   dcc_req_if req_ch ();
   dcc_rsp_if rsp_ch ();

   dcc_command_packet_builder_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch)
   );

   // Two ns period, two delays per cycle.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: its own copy of the speed table, the round-robin pointer, the
   // transaction counter and the active slot register.
   dcc_pkg::slot_entry_type speed_table [0:31];
   logic [4:0]      refresh_slot;
   logic [15:0]     transaction_count;
   logic [4:0]      active_slots;

   // Scratch space for the packet being assembled by the predictor.
   logic [7:0]      packet_body [$];
   logic [15:0]     packet_railcom;
   packet_byte_type predicted_bytes [$];

   // Bytes that the block still owes, oldest first.
   packet_byte_type expected_bytes [$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned mismatch_count;
   int unsigned commands_sent;
   int unsigned bytes_checked;
   int unsigned packets_checked;

   directed_row_type directed_rows [$];

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   task automatic reset_model();
      foreach (speed_table[i]) speed_table[i] = dcc_pkg::SLOT_RESET;
      refresh_slot      = '0;
      transaction_count = '0;
      active_slots      = 5'd31;
   endtask

   // Starts a packet with the short or long address form and records the address bytes.
   task automatic open_packet(input logic [13:0] address);
      logic [7:0] high;
      packet_body    = {};
      packet_railcom = '0;
      if (address > 14'd127) begin
         high = {2'b00, address[13:8]} | dcc_pkg::LONG_ADDR_TAG;
         packet_body.push_back(high);
         packet_railcom[15:8] = high;
      end
      packet_body.push_back(address[7:0]);
      packet_railcom[7:0] = address[7:0];
   endtask

   // Numbers the packet and turns its bytes, plus the XOR checksum, into result items.
   task automatic close_packet(input logic [2:0] repeats, input logic [2:0] kind);
      logic [7:0]      checksum;
      packet_byte_type entry;
      checksum          = '0;
      transaction_count = transaction_count + 16'd1;
      entry.last_byte       = 1'b0;
      entry.packet_valid    = 1'b1;
      entry.status          = 1'b0;
      entry.repeat_count    = repeats;
      entry.packet_kind     = kind;
      entry.railcom_address = packet_railcom;
      entry.transaction_id  = transaction_count;
      foreach (packet_body[i]) begin
         entry.payload_byte = packet_body[i];
         checksum           = checksum ^ packet_body[i];
         predicted_bytes.push_back(entry);
      end
      entry.payload_byte = checksum;
      entry.last_byte    = 1'b1;
      predicted_bytes.push_back(entry);
   endtask

   // 128-step speed packet: step 0 stays 0, other steps move up by one; bit 7 is forward.
   task automatic throttle_packet(input logic [13:0] address, input logic [6:0] speed,
                                  input logic forward);
      logic [6:0] step;
      step = speed + {6'b0, speed != 7'd0};
      open_packet(address);
      packet_body.push_back(dcc_pkg::SPEED_128_OP);
      packet_body.push_back({forward, step});
      close_packet(dcc_pkg::REP_THROTTLE, dcc_pkg::KIND_THROTTLE);
   endtask

   // CV packets carry the zero-based CV number modulo 1024, its top two bits in the opcode.
   task automatic open_cv_packet(input logic [13:0] address, input logic [15:0] cv_number,
                                 input logic [7:0] opcode);
      logic [9:0] cv;
      cv = 10'(cv_number - 16'd1);
      open_packet(address);
      packet_body.push_back(opcode + {6'b0, cv[9:8]});
      packet_body.push_back(cv[7:0]);
   endtask

   // Refresh: walk the valid slots round robin from the pointer, send the first one that
   // holds a nonzero address, and leave the pointer on the slot after it.
   task automatic refresh_packet(input logic queue_empty);
      int unsigned valid_slots;
      int unsigned first;
      int unsigned probe;
      valid_slots = active_slots;
      if (!queue_empty || valid_slots == 0) return;
      first = refresh_slot;
      if (first < 1 || first > valid_slots) first = 1;
      for (int i = 0; i < valid_slots; i++) begin
         probe = first + i;
         if (probe > valid_slots) probe = probe - valid_slots;
         if (speed_table[probe].address != '0) begin
            refresh_slot = (probe + 1 > valid_slots) ? 5'd1 : 5'(probe + 1);
            throttle_packet(speed_table[probe].address, speed_table[probe].speed,
                            speed_table[probe].forward);
            return;
         end
      end
   endtask

   // Works out the result items of one accepted command into predicted_bytes.
   task automatic predict_packet(input command_type command);
      logic [6:0] speed;
      logic [7:0] tail;
      predicted_bytes = {};
      speed = (command.speed > 7'd126) ? 7'd126 : command.speed;
      case (command.action)
         dcc_pkg::ACT_THROTTLE: begin
            if (command.slot < 8'd1 || command.slot > {3'b000, active_slots}) begin
               predicted_bytes.push_back(SLOT_ERROR);
            end else begin
               speed_table[command.slot[4:0]] = '{address: command.address, speed: speed,
                                                  forward: command.direction};
               throttle_packet(command.address, speed, command.direction);
            end
         end
         dcc_pkg::ACT_FUNC_GROUP: begin
            open_packet(command.address);
            packet_body.push_back((command.data_one | dcc_pkg::FUNC_ONE_SET)
                                  & dcc_pkg::FUNC_ONE_MASK);
            close_packet(dcc_pkg::REP_DEFAULT, dcc_pkg::KIND_FUNCTION);
         end
         dcc_pkg::ACT_FUNC_TWO: begin
            open_packet(command.address);
            packet_body.push_back((command.data_one | dcc_pkg::FUNC_TWO_SET)
                                  & dcc_pkg::FUNC_TWO_MASK);
            packet_body.push_back(command.data_two);
            close_packet(dcc_pkg::REP_DEFAULT, dcc_pkg::KIND_FUNCTION);
         end
         dcc_pkg::ACT_ACCESSORY: begin
            // Accessory packets have their own two-byte address layout.
            packet_body = {};
            packet_body.push_back(dcc_pkg::ACC_FIRST_BASE + {2'b00, command.address[5:0]});
            packet_body.push_back({1'b0, command.address[8:6], 1'b0, command.data_one[1:0],
                                   command.direction} ^ dcc_pkg::ACC_SECOND_XOR);
            packet_railcom = {packet_body[0], packet_body[1]};
            close_packet(dcc_pkg::REP_DEFAULT, dcc_pkg::KIND_ACCESSORY);
         end
         dcc_pkg::ACT_CV_WRITE: begin
            open_cv_packet(command.address, command.cv_number, dcc_pkg::OP_CV_WRITE);
            packet_body.push_back(command.data_one);
            close_packet(dcc_pkg::REP_DEFAULT, dcc_pkg::KIND_CV_WRITE);
         end
         dcc_pkg::ACT_CV_BIT: begin
            tail = dcc_pkg::CV_BIT_BASE + {4'h0, command.data_one[0], command.data_two[2:0]};
            open_cv_packet(command.address, command.cv_number, dcc_pkg::OP_CV_BIT);
            packet_body.push_back(tail);
            close_packet(dcc_pkg::REP_CV_BIT, dcc_pkg::KIND_CV_BIT);
         end
         dcc_pkg::ACT_CV_READ: begin
            open_cv_packet(command.address, command.cv_number, dcc_pkg::OP_CV_READ);
            packet_body.push_back(8'h00);
            close_packet(dcc_pkg::REP_DEFAULT, dcc_pkg::KIND_CV_READ);
         end
         dcc_pkg::ACT_CV_LONG: begin
            open_cv_packet(command.address, command.cv_number, dcc_pkg::OP_CV_LONG);
            close_packet(dcc_pkg::REP_DEFAULT, dcc_pkg::KIND_CV_LONG);
         end
         dcc_pkg::ACT_REFRESH: refresh_packet(command.queue_empty);
         default: ;   // Unknown actions are dropped without a result.
      endcase
   endtask

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------

   function automatic command_type make_command(
      input logic [3:0] action, input logic [7:0] slot, input logic [13:0] address,
      input logic [6:0] speed, input logic direction, input logic [7:0] data_one,
      input logic [7:0] data_two, input logic [15:0] cv_number, input logic queue_empty);
      command_type command;
      command = '{action, slot, address, speed, direction, data_one, data_two, cv_number,
                  queue_empty};
      return command;
   endfunction

   task automatic add_row(input expect_kind_type kind, input command_type command);
      directed_row_type row;
      row.kind    = kind;
      row.command = command;
      directed_rows.push_back(row);
   endtask

   // Addresses lean on the boundary between the short and long forms.
   function automatic logic [13:0] random_address();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0) begin
         case ($urandom_range(3))
            0:       return 14'd0;
            1:       return 14'd127;
            2:       return 14'd128;
            default: return 14'd16383;
         endcase
      end
      if (pick < 5) return 14'($urandom_range(127));
      return 14'($urandom_range(16383));
   endfunction

   function automatic logic [15:0] random_cv_number();
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(3))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd1024;
            default: return 16'hFFFF;
         endcase
      end
      return 16'($urandom);
   endfunction

   // Mostly well-formed traffic: throttles that fill the table, refreshes with an empty
   // queue, and the other packet types; a few bad slots, busy refreshes and unknown codes.
   function automatic command_type random_command();
      command_type command;
      int unsigned pick;
      command           = command_type'({$urandom, $urandom, $urandom});
      command.address   = random_address();
      command.cv_number = random_cv_number();
      pick = $urandom_range(99);
      if (pick < 35) begin
         command.action = dcc_pkg::ACT_THROTTLE;
         if ($urandom_range(99) < 85)
            command.slot = 8'($urandom_range(active_slots, 1));
         else if ($urandom_range(1) == 0)
            command.slot = 8'd0;
         else
            command.slot = 8'($urandom_range(255, active_slots + 1));
         if ($urandom_range(19) == 0) command.address = '0;
      end else if (pick < 60) begin
         command.action      = dcc_pkg::ACT_REFRESH;
         command.queue_empty = ($urandom_range(9) != 0);
      end else if (pick < 94) begin
         command.action = 4'($urandom_range(dcc_pkg::ACT_CV_LONG, dcc_pkg::ACT_FUNC_GROUP));
      end else begin
         command.action = 4'($urandom_range(15, dcc_pkg::ACT_REFRESH + 1));
      end
      return command;
   endfunction

   // Offers one command, with a random gap first, and waits for the block to take it.
   // Ready is sampled at the falling edge, so the decision matches the next rising edge.
   task automatic send_command(input command_type command);
      logic taken;
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= command.action;
      req_ch.slot        <= command.slot;
      req_ch.address     <= command.address;
      req_ch.speed       <= command.speed;
      req_ch.direction   <= command.direction;
      req_ch.data_one    <= command.data_one;
      req_ch.data_two    <= command.data_two;
      req_ch.cv_number   <= command.cv_number;
      req_ch.queue_empty <= command.queue_empty;
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
      commands_sent++;
      predict_packet(command);
   endtask

   // Waits for every owed byte, then long enough for a refresh that emits nothing to end.
   task automatic wait_until_drained();
      int unsigned guard;
      guard = 0;
      while (expected_bytes.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active_slots(input logic [4:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_slots = value;
   endtask

   function automatic string describe(input packet_byte_type p);
      return $sformatf("byte=%02h last=%0d pv=%0d st=%0d rep=%0d kind=%0d rc=%04h id=%04h",
                       p.payload_byte, p.last_byte, p.packet_valid, p.status,
                       p.repeat_count, p.packet_kind, p.railcom_address, p.transaction_id);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Result side: random backpressure, and a checker that compares each accepted byte
   // with the oldest expectation.
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Outputs come from a register and ready changes only at the rising edge, so the
   // falling edge sees exactly what the next rising edge will accept.
   always @(negedge clock) begin
      packet_byte_type seen;
      packet_byte_type wanted;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen = '{rsp_ch.payload_byte, rsp_ch.last_byte, rsp_ch.packet_valid, rsp_ch.status,
                  rsp_ch.repeat_count, rsp_ch.packet_kind, rsp_ch.railcom_address,
                  rsp_ch.transaction_id};
         bytes_checked++;
         if (seen.last_byte && seen.packet_valid) packets_checked++;
         if (expected_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: unexpected item", $realtime);
               $display("   expected none");
               $display("   actual   %s", describe(seen));
            end
         end else begin
            wanted = expected_bytes.pop_front();
            if (seen !== wanted) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: item differs", $realtime);
                  $display("   expected %s", describe(wanted));
                  $display("   actual   %s", describe(seen));
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      logic [4:0]  phase_slots [3];
      int unsigned phase_send [3];
      int unsigned phase_recv [3];
      int unsigned counted;
      command_type command;

      // The request side and the register port start from known values; the receiver's
      // ready is driven by its own process from the first clock edge.
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      req_ch.valid       = 1'b0;
      req_ch.action      = '0;
      req_ch.slot        = '0;
      req_ch.address     = '0;
      req_ch.speed       = '0;
      req_ch.direction   = 1'b0;
      req_ch.data_one    = '0;
      req_ch.data_two    = '0;
      req_ch.cv_number   = '0;
      req_ch.queue_empty = 1'b0;
      send_idle_pct      = 0;
      recv_idle_pct      = 0;
      mismatch_count     = 0;
      commands_sent      = 0;
      bytes_checked      = 0;
      packets_checked    = 0;
      reset_model();

      // Directed commands, run with the slot count left at its reset value of 31.
      // With an empty table a refresh has nothing to send.
      add_row(EXP_NONE, make_command(dcc_pkg::ACT_REFRESH, 8'd0, 14'd0, 7'd0, 1'b0,
                                     8'h00, 8'h00, 16'd0, 1'b1));
      // Slot zero and slots past the valid count are rejected with the error item.
      add_row(EXP_SLOT_ERROR, make_command(dcc_pkg::ACT_THROTTLE, 8'd0, 14'd5, 7'd10, 1'b1,
                                           8'h00, 8'h00, 16'd1, 1'b1));
      add_row(EXP_SLOT_ERROR, make_command(dcc_pkg::ACT_THROTTLE, 8'd32, 14'd5, 7'd10, 1'b1,
                                           8'h00, 8'h00, 16'd1, 1'b1));
      add_row(EXP_SLOT_ERROR, make_command(dcc_pkg::ACT_THROTTLE, 8'd255, 14'd16383, 7'd127,
                                           1'b0, 8'hFF, 8'hFF, 16'hFFFF, 1'b0));
      // Throttles at the speed and address extremes; 127 must saturate to 126.
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_THROTTLE, 8'd1, 14'd3, 7'd0, 1'b0,
                                        8'h00, 8'h00, 16'd0, 1'b0));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_THROTTLE, 8'd31, 14'd16383, 7'd127, 1'b1,
                                        8'hFF, 8'hFF, 16'hFFFF, 1'b1));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_THROTTLE, 8'd2, 14'd127, 7'd1, 1'b1,
                                        8'h00, 8'h00, 16'd0, 1'b0));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_THROTTLE, 8'd3, 14'd128, 7'd126, 1'b0,
                                        8'h00, 8'h00, 16'd0, 1'b0));
      // A busy queue blocks refresh; then refresh walks slots 1, 2 and 3.
      add_row(EXP_NONE, make_command(dcc_pkg::ACT_REFRESH, 8'd0, 14'd0, 7'd0, 1'b0,
                                     8'h00, 8'h00, 16'd0, 1'b0));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_REFRESH, 8'd0, 14'd0, 7'd0, 1'b0,
                                        8'h00, 8'h00, 16'd0, 1'b1));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_REFRESH, 8'd0, 14'd0, 7'd0, 1'b0,
                                        8'h00, 8'h00, 16'd0, 1'b1));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_REFRESH, 8'd0, 14'd0, 7'd0, 1'b0,
                                        8'h00, 8'h00, 16'd0, 1'b1));
      // A throttle to address zero is sent but leaves its slot out of the refresh cycle,
      // so the next refreshes skip ahead to slot 31 and wrap back to slot 1.
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_THROTTLE, 8'd2, 14'd0, 7'd50, 1'b1,
                                        8'h00, 8'h00, 16'd0, 1'b0));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_REFRESH, 8'd0, 14'd0, 7'd0, 1'b0,
                                        8'h00, 8'h00, 16'd0, 1'b1));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_REFRESH, 8'd0, 14'd0, 7'd0, 1'b0,
                                        8'h00, 8'h00, 16'd0, 1'b1));
      // Function, accessory and CV packets, with CV numbers 0, 1, 1024 and 65535.
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_FUNC_GROUP, 8'd0, 14'd0, 7'd0, 1'b0,
                                        8'hFF, 8'h00, 16'd0, 1'b0));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_FUNC_GROUP, 8'd0, 14'd16383, 7'd0, 1'b0,
                                        8'h00, 8'hFF, 16'd0, 1'b0));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_FUNC_TWO, 8'd0, 14'd200, 7'd0, 1'b0,
                                        8'h00, 8'hFF, 16'd0, 1'b0));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_ACCESSORY, 8'd0, 14'd16383, 7'd0, 1'b1,
                                        8'hFF, 8'h00, 16'd0, 1'b0));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_ACCESSORY, 8'd0, 14'd0, 7'd0, 1'b0,
                                        8'h00, 8'h00, 16'd0, 1'b0));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_CV_WRITE, 8'd0, 14'd5, 7'd0, 1'b0,
                                        8'hFF, 8'h00, 16'd0, 1'b0));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_CV_BIT, 8'd0, 14'd9000, 7'd0, 1'b0,
                                        8'h01, 8'h07, 16'hFFFF, 1'b0));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_CV_READ, 8'd0, 14'd127, 7'd0, 1'b0,
                                        8'h00, 8'h00, 16'd1, 1'b0));
      add_row(EXP_PREDICT, make_command(dcc_pkg::ACT_CV_LONG, 8'd0, 14'd16383, 7'd0, 1'b0,
                                        8'h00, 8'h00, 16'd1024, 1'b0));
      // Codes past refresh are dropped.
      add_row(EXP_NONE, make_command(4'd9, 8'd1, 14'd1, 7'd1, 1'b1,
                                     8'h00, 8'h00, 16'd1, 1'b1));
      add_row(EXP_NONE, make_command(4'd15, 8'd1, 14'd1, 7'd1, 1'b1,
                                     8'hFF, 8'hFF, 16'd1, 1'b1));

      // Synchronous reset, released at a rising edge.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // For typed rows the predictor still runs, so its state follows the block, but the
      // expectation queued is the one written in the table.
      foreach (directed_rows[i]) begin
         send_command(directed_rows[i].command);
         case (directed_rows[i].kind)
            EXP_PREDICT: begin
               foreach (predicted_bytes[j]) expected_bytes.push_back(predicted_bytes[j]);
            end
            EXP_SLOT_ERROR: expected_bytes.push_back(SLOT_ERROR);
            default:        ;
         endcase
      end
      req_ch.valid <= 1'b0;
      wait_until_drained();

      // Random phases: a middle slot count with a slow receiver, the single-slot minimum
      // with a slow sender, then the full 31 slots with no idling on either side.
      phase_slots = '{5'd5, 5'd1, 5'd31};
      phase_send  = '{15, 79, 0};
      phase_recv  = '{79, 15, 0};
      for (int phase = 0; phase < 3; phase++) begin
         write_active_slots(phase_slots[phase]);
         send_idle_pct = phase_send[phase];
         recv_idle_pct = phase_recv[phase];
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            command = random_command();
            send_command(command);
            foreach (predicted_bytes[j]) expected_bytes.push_back(predicted_bytes[j]);
            if (command.action <= dcc_pkg::ACT_REFRESH) counted++;
         end
         req_ch.valid <= 1'b0;
         wait_until_drained();
      end

      $display("Ran %0d commands under slot counts 31, 5, 1 and 31 with mixed backpressure;",
               commands_sent);
      $display("checked %0d result bytes forming %0d packets.", bytes_checked,
               packets_checked);
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("dcc_command_packet_builder_core: match");
      end else begin
         $display("%0d mismatches, %0d bytes never arrived", mismatch_count,
                  expected_bytes.size());
         $display("dcc_command_packet_builder_core: mismatch");
      end
      $finish;
   end

   // Hard stop far beyond the slowest legitimate run.
   initial begin
      #2000000;
      $display("Run timed out");
      $display("dcc_command_packet_builder_core: mismatch");
      $finish;
   end

endmodule
